### hw/rtl/bftk_pkg.sv
// Shared types, constants and codes for the top-k nearest neighbour block
package bftk_pkg;

   localparam int MaxDimsDefault      = 256;
   localparam int MaxNeighborsDefault = 16;
   localparam int DistWidth           = 42;
   localparam int IdWidth             = 31;
   localparam int ElemWidth           = 16;
   localparam int RankWidth           = 4;
   localparam int CsrDataWidth        = 31;
   localparam int CsrIndexWidth       = 2;

   // input commands
   localparam logic [1:0] CMD_QUERY  = 2'd0;
   localparam logic [1:0] CMD_DBASE  = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;
   localparam logic [1:0] CMD_UNUSED = 2'd3; // ignored, no results

   // configuration register indexes
   localparam logic [CsrIndexWidth-1:0] CSR_METRIC = 2'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_K      = 2'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LENGTH = 2'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_BASE   = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_QREAD,
      ST_ACCUM,
      ST_INSERT,
      ST_EMIT
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic qwrite;     // store query element
      logic qread;      // read query element for current database element
      logic accum;      // accumulate product with held element
      logic insert;     // insert accumulated vector into list
      logic emit_start; // latch result count and reset rank
      logic emit_load;  // show list head on output register
      logic emit_shift; // pop list head
      logic finish_clr; // clear list and counters
   } ctrl_type;

   // datapath status
   typedef struct packed {
      logic vec_done;   // last accumulated element completed the vector
      logic list_empty; // nothing more to emit
      logic emit_last;  // head is the final result
   } stat_type;

endpackage

### hw/rtl/bftk_ram.sv
// Generic simple dual-port RAM (separate write and read ports) with registered read
module bftk_ram #(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/bftk_ctrl.sv
// Controller state machine for the top-k nearest neighbour block
module bftk_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_cmd,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bftk_pkg::ctrl_type  ctrl,
   input  bftk_pkg::stat_type  stat
);

   bftk_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bftk_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      logic acc;
      acc          = 1'b0;
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      ctrl         = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         bftk_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            acc       = req_valid;
            if (acc) begin
               priority if (req_cmd == bftk_pkg::CMD_QUERY) begin
                  ctrl.qwrite = 1'b1;
               end else if (req_cmd == bftk_pkg::CMD_DBASE) begin
                  ctrl.qread = 1'b1;
                  state_in   = bftk_pkg::ST_QREAD;
               end else if (req_cmd == bftk_pkg::CMD_FINISH) begin
                  ctrl.emit_start = 1'b1;
                  state_in        = bftk_pkg::ST_EMIT;
               end else begin
                  state_in = bftk_pkg::ST_IDLE;
               end
            end
         end
         bftk_pkg::ST_QREAD: begin
            state_in = bftk_pkg::ST_ACCUM;
         end
         bftk_pkg::ST_ACCUM: begin
            ctrl.accum = 1'b1;
            state_in   = bftk_pkg::ST_INSERT;
         end
         bftk_pkg::ST_INSERT: begin
            ctrl.insert = stat.vec_done;
            state_in    = bftk_pkg::ST_IDLE;
         end
         bftk_pkg::ST_EMIT: begin
            // one result at a time through the output register
            if (!rsp_valid_ff || rsp_ready) begin
               if (stat.list_empty) begin
                  rsp_valid_in    = 1'b0;
                  ctrl.finish_clr = 1'b1;
                  state_in        = bftk_pkg::ST_IDLE;
               end else begin
                  rsp_valid_in    = 1'b1;
                  ctrl.emit_load  = 1'b1;
                  ctrl.emit_shift = 1'b1;
               end
            end
         end
         default: begin
            state_in = bftk_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // a result only stands while emitting or draining the last one
   a_rsp_state: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == bftk_pkg::ST_EMIT || state_ff == bftk_pkg::ST_IDLE))
      else $error("result valid outside emission");
   a_accum_seq: assert property (@(posedge clock) disable iff (reset)
      state_ff == bftk_pkg::ST_QREAD |=> state_ff == bftk_pkg::ST_ACCUM)
      else $error("query read not followed by accumulate");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> state_ff == bftk_pkg::ST_IDLE)
      else $error("item accepted while busy");

endmodule

### hw/rtl/bftk_dpath.sv
// Datapath: query store, distance accumulator and sorted top-k list
module bftk_dpath #(
   parameter int MaxDims      = bftk_pkg::MaxDimsDefault,
   parameter int MaxNeighbors = bftk_pkg::MaxNeighborsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  bftk_pkg::ctrl_type                   ctrl,
   output bftk_pkg::stat_type                   stat,
   input  logic signed [bftk_pkg::ElemWidth-1:0] elem,
   input  logic                                 csr_write_enable,
   input  logic [bftk_pkg::CsrIndexWidth-1:0]   csr_index,
   input  logic [bftk_pkg::CsrDataWidth-1:0]    csr_write_data,
   output logic signed [bftk_pkg::DistWidth-1:0] rsp_distance,
   output logic [bftk_pkg::IdWidth-1:0]         rsp_neighbor_id,
   output logic [bftk_pkg::RankWidth-1:0]       rsp_rank,
   output logic                                 rsp_last
);

   localparam int AddrW = (MaxDims > 1) ? $clog2(MaxDims) : 1;
   localparam int LenW  = $clog2(MaxDims + 1);
   localparam int KW    = $clog2(MaxNeighbors + 1);
   localparam int AccW  = bftk_pkg::DistWidth - 1;
   localparam int IdW   = bftk_pkg::IdWidth;
   localparam int RW    = bftk_pkg::RankWidth;

   // configuration registers
   logic        metric_ff;
   logic [4:0]  k_ff;
   logic [8:0]  len_ff;
   logic [IdW-1:0] base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         metric_ff <= 1'b1;
         k_ff      <= 5'd16;
         len_ff    <= 9'd256;
         base_ff   <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            bftk_pkg::CSR_METRIC: metric_ff <= csr_write_data[0];
            bftk_pkg::CSR_K:      k_ff      <= csr_write_data[4:0];
            bftk_pkg::CSR_LENGTH: len_ff    <= csr_write_data[8:0];
            bftk_pkg::CSR_BASE:   base_ff   <= csr_write_data[IdW-1:0];
            default: ;
         endcase
      end
   end

   // effective length and k, clamped
   logic [LenW-1:0] len_eff;
   logic [KW-1:0]   k_eff;
   always_comb begin
      if (len_ff == 9'd0) len_eff = LenW'(1);
      else if (32'(len_ff) > MaxDims) len_eff = LenW'(MaxDims);
      else len_eff = LenW'(len_ff);
      if (k_ff == 5'd0) k_eff = KW'(1);
      else if (32'(k_ff) > MaxNeighbors) k_eff = KW'(MaxNeighbors);
      else k_eff = KW'(k_ff);
   end

   // counters
   logic [LenW-1:0] qfill_ff, qfill_in, eidx_ff, eidx_in;
   logic [IdW-1:0]  vidx_ff;
   logic signed [AccW-1:0] acc_ff;
   logic signed [bftk_pkg::ElemWidth-1:0] elem_ff;
   logic            done_ff;
   logic [LenW-1:0] qpos;

   assign qpos = (qfill_ff >= len_eff) ? '0 : qfill_ff;
   always_comb begin
      qfill_in = qpos + LenW'(1);
      if (qfill_in >= len_eff) qfill_in = '0;
      eidx_in = eidx_ff + LenW'(1);
   end

   // query memory
   logic signed [bftk_pkg::ElemWidth-1:0] q_rd;
   bftk_ram #(.Width(bftk_pkg::ElemWidth), .Depth(MaxDims)) u_qram (
      .clock   (clock),
      .wr_en   (ctrl.qwrite),
      .wr_addr (qpos[AddrW-1:0]),
      .wr_data (elem),
      .rd_en   (ctrl.qread),
      .rd_addr (eidx_ff[AddrW-1:0]),
      .rd_data (q_rd)
   );

   // one product per element
   logic signed [bftk_pkg::ElemWidth:0] diff;
   logic signed [33:0] prod;
   always_comb begin
      diff = 17'(q_rd) - 17'(elem_ff);
      if (metric_ff) prod = 34'(diff) * 34'(diff);
      else           prod = -(34'(q_rd) * 34'(elem_ff));
   end

   // sorted list, compare-shift cells
   logic signed [AccW-1:0] bd_ff [MaxNeighbors];
   logic [IdW-1:0]         bi_ff [MaxNeighbors];
   logic [KW-1:0]          fill_ff;
   logic [RW-1:0]          rank_ff;
   logic [KW-1:0]          left_ff;
   logic [IdW-1:0]         new_id;
   logic [MaxNeighbors-1:0] ahead;

   assign new_id = base_ff + vidx_ff;
   always_comb begin
      for (int i = 0; i < MaxNeighbors; i++) begin
         ahead[i] = (32'(fill_ff) <= i) || (acc_ff < bd_ff[i]) ||
                    (acc_ff == bd_ff[i] && new_id < bi_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.insert) begin
         for (int i = 0; i < MaxNeighbors; i++) begin
            if (ahead[i]) begin
               if (i == 0 || !ahead[(i == 0) ? 0 : i-1]) begin
                  bd_ff[i] <= acc_ff;
                  bi_ff[i] <= new_id;
               end else begin
                  bd_ff[i] <= bd_ff[(i == 0) ? 0 : i-1];
                  bi_ff[i] <= bi_ff[(i == 0) ? 0 : i-1];
               end
            end
         end
      end else if (ctrl.emit_shift) begin
         for (int i = 0; i < MaxNeighbors - 1; i++) begin
            bd_ff[i] <= bd_ff[i+1];
            bi_ff[i] <= bi_ff[i+1];
         end
      end
   end

   // control counters
   always_ff @(posedge clock) begin
      if (reset) begin
         qfill_ff <= '0;
         eidx_ff  <= '0;
         vidx_ff  <= '0;
         acc_ff   <= '0;
         fill_ff  <= '0;
         done_ff  <= 1'b0;
         rank_ff  <= '0;
         left_ff  <= '0;
      end else begin
         if (ctrl.qwrite) qfill_ff <= qfill_in;
         if (ctrl.accum) begin
            done_ff <= eidx_in >= len_eff;
            eidx_ff <= (eidx_in >= len_eff) ? '0 : eidx_in;
            acc_ff  <= acc_ff + AccW'(prod);
         end
         if (ctrl.insert) begin
            acc_ff  <= '0;
            vidx_ff <= vidx_ff + IdW'(1);
            if (32'(fill_ff) < MaxNeighbors) fill_ff <= fill_ff + KW'(1);
         end
         // result count is fixed when the finish item is taken
         if (ctrl.emit_load) begin
            rank_ff <= rank_ff + RW'(1);
            left_ff <= left_ff - KW'(1);
         end else if (ctrl.emit_start) begin
            rank_ff <= '0;
            left_ff <= (fill_ff < k_eff) ? fill_ff : k_eff;
         end
         if (ctrl.finish_clr) begin
            fill_ff <= '0;
            vidx_ff <= '0;
            eidx_ff <= '0;
            acc_ff  <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.qread) elem_ff <= elem;
   end

   // output register
   always_ff @(posedge clock) begin
      if (ctrl.emit_load) begin
         rsp_distance    <= bftk_pkg::DistWidth'(bd_ff[0]);
         rsp_neighbor_id <= bi_ff[0];
         rsp_rank        <= rank_ff;
         rsp_last        <= left_ff == KW'(1);
      end
   end

   assign stat.vec_done   = done_ff;
   assign stat.list_empty = left_ff == '0;
   assign stat.emit_last  = left_ff == KW'(1);

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= MaxNeighbors) else $error("list fill overflow");
   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit_load |-> !stat.list_empty) else $error("emit from empty list");
   a_clr: assert property (@(posedge clock) disable iff (reset)
      ctrl.finish_clr |=> fill_ff == '0) else $error("list not cleared");

endmodule

### hw/rtl/brute_force_topk_nearest_top.sv
// Top level of the brute-force top-k nearest neighbour block
//  channel | ports                          | direction
//  req     | req_valid/ready, cmd, element  | in
//  rsp     | rsp_valid/ready, distance..last| out
//  csr     | csr_write_enable/index/data    | in
// Query element: stored on accept. Database element passes accept, memory read,
// multiply-accumulate and list insert by compare-shift cells, in that order.
// Finish: accept, then results one at a time while rsp_ready is high,
// and then the list is cleared.
// Reset is synchronous; list and query store contents are not cleared.
// Results hold while rsp_ready is low; no item is taken during emission.
module brute_force_topk_nearest_top #(
   parameter int MaxDims      = bftk_pkg::MaxDimsDefault,
   parameter int MaxNeighbors = bftk_pkg::MaxNeighborsDefault
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [1:0]                            req_cmd,
   input  logic signed [bftk_pkg::ElemWidth-1:0] req_element_value,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [bftk_pkg::DistWidth-1:0] rsp_distance,
   output logic [bftk_pkg::IdWidth-1:0]          rsp_neighbor_id,
   output logic [bftk_pkg::RankWidth-1:0]        rsp_rank,
   output logic                                  rsp_last,
   input  logic                                  csr_write_enable,
   input  logic [bftk_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [bftk_pkg::CsrDataWidth-1:0]     csr_write_data
);

   bftk_pkg::ctrl_type ctrl;
   bftk_pkg::stat_type stat;

   bftk_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_cmd   (req_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctrl      (ctrl),
      .stat      (stat)
   );

   bftk_dpath #(.MaxDims(MaxDims), .MaxNeighbors(MaxNeighbors)) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctrl             (ctrl),
      .stat             (stat),
      .elem             (req_element_value),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .rsp_distance     (rsp_distance),
      .rsp_neighbor_id  (rsp_neighbor_id),
      .rsp_rank         (rsp_rank),
      .rsp_last         (rsp_last)
   );

endmodule

### bench/tb_brute_force_topk_nearest_top.sv
// Self-checking testbench for the brute-force top-k nearest neighbour block
`timescale 1ns / 100ps

module tb_brute_force_topk_nearest_top;

   localparam int Dims       = 256;
   localparam int Neighbors  = 16;
   localparam int IdleLimit  = 4000;
   localparam int LongLength = 40;
   localparam int IdW        = bftk_pkg::IdWidth;
   localparam int CsrW       = bftk_pkg::CsrDataWidth;

   typedef struct {
      logic [bftk_pkg::DistWidth-1:0] distance;
      logic [IdW-1:0]                 neighbor_id;
      logic [bftk_pkg::RankWidth-1:0] rank;
      logic                           last;
   } neighbour_type;

   bit clock = 1'b0;
   bit reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [1:0] req_cmd = bftk_pkg::CMD_QUERY;
   logic signed [bftk_pkg::ElemWidth-1:0] req_element_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [bftk_pkg::DistWidth-1:0] rsp_distance;
   logic [IdW-1:0] rsp_neighbor_id;
   logic [bftk_pkg::RankWidth-1:0] rsp_rank;
   logic rsp_last;
   logic csr_write_enable = 1'b0;
   logic [bftk_pkg::CsrIndexWidth-1:0] csr_index = bftk_pkg::CSR_METRIC;
   logic [CsrW-1:0] csr_write_data = '0;

   // mirror of the block state
   bit                   metric_sq = 1'b1;
   bit [4:0]             k_reg = 5'd16;
   bit [8:0]             length_reg = 9'd256;
   bit [IdW-1:0]         base_reg = '0;
   logic signed [15:0]   query_mem [Dims];
   bit                   query_known [Dims];
   int unsigned          query_pos = 0;
   int unsigned          elem_pos = 0;
   longint               partial_dist = 0;
   bit [IdW-1:0]         vec_count = '0;
   longint               ranked_dist [Neighbors];
   bit [IdW-1:0]         ranked_id [Neighbors];
   int unsigned          ranked_fill = 0;

   neighbour_type pending_neighbours[$];
   int failures = 0;
   int items_sent = 0;
   int results_seen = 0;
   int idle_cycles = 0;
   int hold_left = 0;
   int long_stall_cycles = 0;
   bit long_stall_started = 1'b0;

   brute_force_topk_nearest_top dut (.*);

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // ---------------- predictor ----------------
   function automatic int unsigned used_length();
      if (length_reg == 0) return 1;
      if (length_reg > Dims) return Dims;
      return 32'(length_reg);
   endfunction

   function automatic int unsigned used_k();
      if (k_reg == 0) return 1;
      if (k_reg > Neighbors) return Neighbors;
      return 32'(k_reg);
   endfunction

   function automatic bit nearer(longint da, bit [IdW-1:0] ia,
                                 longint db, bit [IdW-1:0] ib);
      return (da < db) || (da == db && ia < ib);
   endfunction

   function automatic void rank_insert(longint d, bit [IdW-1:0] id);
      int unsigned pos;
      if (ranked_fill >= Neighbors) begin
         if (!nearer(d, id, ranked_dist[Neighbors-1], ranked_id[Neighbors-1])) return;
         pos = Neighbors - 1;
      end else begin
         pos = ranked_fill;
         ranked_fill++;
      end
      while (pos > 0 && nearer(d, id, ranked_dist[pos-1], ranked_id[pos-1])) begin
         ranked_dist[pos] = ranked_dist[pos-1];
         ranked_id[pos] = ranked_id[pos-1];
         pos--;
      end
      ranked_dist[pos] = d;
      ranked_id[pos] = id;
   endfunction

   function automatic void predict_item(logic [1:0] cmd, logic signed [15:0] value);
      int unsigned len;
      int unsigned take;
      longint q;
      longint diff;
      neighbour_type n;
      len = used_length();
      unique case (cmd)
         bftk_pkg::CMD_QUERY: begin
            if (query_pos >= len) query_pos = 0;
            query_mem[query_pos % Dims] = value;
            query_known[query_pos % Dims] = 1'b1;
            query_pos++;
            if (query_pos >= len) query_pos = 0;
         end
         bftk_pkg::CMD_DBASE: begin
            q = query_mem[elem_pos % Dims];
            if (!metric_sq) begin
               partial_dist -= q * longint'(value);
            end else begin
               diff = q - longint'(value);
               partial_dist += diff * diff;
            end
            elem_pos++;
            if (elem_pos >= len) begin
               rank_insert(partial_dist, base_reg + vec_count);
               vec_count = vec_count + 1'b1;
               elem_pos = 0;
               partial_dist = 0;
            end
         end
         bftk_pkg::CMD_FINISH: begin
            take = (ranked_fill < used_k()) ? ranked_fill : used_k();
            for (int unsigned r = 0; r < take; r++) begin
               n.distance = ranked_dist[r][bftk_pkg::DistWidth-1:0];
               n.neighbor_id = ranked_id[r];
               n.rank = r[bftk_pkg::RankWidth-1:0];
               n.last = (r + 1 == take);
               pending_neighbours.push_back(n);
            end
            ranked_fill = 0;
            vec_count = '0;
            elem_pos = 0;
            partial_dist = 0;
         end
         default: ;
      endcase
   endfunction

   // ---------------- driving ----------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // called and returns at a falling edge; valid stays high for back-to-back items
   task automatic send_item(logic [1:0] cmd, logic signed [15:0] value, bit gaps = 1'b1);
      int gap;
      gap = gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_element_value <= value;
      do @(posedge clock); while (!req_ready);
      predict_item(cmd, value);
      items_sent++;
      @(negedge clock);
   endtask

   // database element, falling back to a query element where the store slot is unwritten
   task automatic send_db(logic signed [15:0] value, bit gaps = 1'b1);
      if (query_known[elem_pos % Dims]) send_item(bftk_pkg::CMD_DBASE, value, gaps);
      else send_item(bftk_pkg::CMD_QUERY, value, gaps);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_neighbours.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic set_reg(logic [bftk_pkg::CsrIndexWidth-1:0] idx, logic [CsrW-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      case (idx)
         bftk_pkg::CSR_METRIC: metric_sq = data[0];
         bftk_pkg::CSR_K:      k_reg = data[4:0];
         bftk_pkg::CSR_LENGTH: length_reg = data[8:0];
         bftk_pkg::CSR_BASE:   base_reg = data[IdW-1:0];
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic configure(bit m, int k, int len, bit [IdW-1:0] base);
      wait_idle();
      set_reg(bftk_pkg::CSR_METRIC, CsrW'(m));
      set_reg(bftk_pkg::CSR_K, CsrW'(k));
      set_reg(bftk_pkg::CSR_LENGTH, CsrW'(len));
      set_reg(bftk_pkg::CSR_BASE, CsrW'(base));
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic signed [15:0] rand_elem();
      case ($urandom_range(0, 5))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic load_query();
      repeat (used_length()) send_item(bftk_pkg::CMD_QUERY, rand_elem());
   endtask

   // ---------------- receiver and checking ----------------
   // random ready with short and occasional long holds, plus one requested long stall
   always @(negedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (long_stall_cycles != 0 && !long_stall_started) begin
         long_stall_started <= 1'b1;
         rsp_ready <= 1'b0;
         hold_left <= long_stall_cycles;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (r < 2) begin
         rsp_ready <= 1'b0;
         hold_left <= $urandom_range(10, 40);
      end else begin
         rsp_ready <= (r < 80);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen++;
         if (pending_neighbours.size() == 0) begin
            $error("unexpected neighbour: distance %0d id %0d", rsp_distance, rsp_neighbor_id);
            failures++;
         end else begin
            neighbour_type e;
            e = pending_neighbours.pop_front();
            if (rsp_distance !== e.distance) begin
               $error("distance: expected %0d, got %0d", $signed(e.distance), rsp_distance);
               failures++;
            end
            if (rsp_neighbor_id !== e.neighbor_id) begin
               $error("neighbor_id: expected %0d, got %0d", e.neighbor_id, rsp_neighbor_id);
               failures++;
            end
            if (rsp_rank !== e.rank) begin
               $error("rank: expected %0d, got %0d", e.rank, rsp_rank);
               failures++;
            end
            if (rsp_last !== e.last) begin
               $error("last: expected %0d, got %0d", e.last, rsp_last);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("watchdog: no progress for %0d cycles", IdleLimit);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // ---------------- tests ----------------
   // both metrics with extreme elements, ties on equal vectors
   task automatic test_metrics_and_ties();
      configure(1'b1, 16, 2, '0);
      send_item(bftk_pkg::CMD_QUERY, 16'sh8000);
      send_item(bftk_pkg::CMD_QUERY, 16'sh7fff);
      send_db(16'sh7fff); send_db(16'sh8000);
      send_db(16'sh0001); send_db(16'sh0001);
      send_db(16'sh0001); send_db(16'sh0001);
      send_item(bftk_pkg::CMD_FINISH, '0);
      configure(1'b0, 16, 2, '0);
      send_db(16'sh8000); send_db(16'sh7fff);
      send_db(16'sh7fff); send_db(16'sh8000);
      send_item(bftk_pkg::CMD_FINISH, '0);
   endtask

   // empty finish, partial vector, unused command, id wrap, mid-vector changes
   task automatic test_special_cases();
      configure(1'b1, 1, 4, 31'h7fff_fffe);
      send_item(bftk_pkg::CMD_FINISH, '0);
      load_query();
      send_item(bftk_pkg::CMD_UNUSED, 16'sh1234);
      send_db(16'sh0010); send_db(16'sh0020);
      send_item(bftk_pkg::CMD_FINISH, '0);
      repeat (12) send_db(rand_elem());
      send_item(bftk_pkg::CMD_FINISH, '0);
      configure(1'b1, 31, 4, 31'h7fff_fffe);
      send_db(16'sh0005); send_db(16'sh0006);
      wait_idle();
      set_reg(bftk_pkg::CSR_METRIC, CsrW'(0));
      set_reg(bftk_pkg::CSR_LENGTH, CsrW'(2));
      csr_write_enable <= 1'b0;
      send_db(16'sh0007);
      send_item(bftk_pkg::CMD_FINISH, '0);
   endtask

   // more vectors than the list holds, with small and out-of-range k
   task automatic test_full_list();
      configure(1'b1, 0, 1, 31'd100);
      load_query();
      repeat (24) send_db(16'($urandom_range(0, 7)));
      send_item(bftk_pkg::CMD_FINISH, '0);
      configure(1'b0, 16, 0, 31'd5);
      repeat (20) send_db(rand_elem());
      send_item(bftk_pkg::CMD_FINISH, '0);
   endtask

   // long vectors of extreme elements under both metrics
   task automatic test_long_vector();
      configure(1'b1, 16, LongLength, 31'h7fff_ffff);
      load_query();
      repeat (LongLength) send_db(rand_elem(), 1'b0);
      send_item(bftk_pkg::CMD_FINISH, '0);
      configure(1'b0, 16, LongLength, 31'h7fff_ffff);
      repeat (LongLength) send_db(rand_elem(), 1'b0);
      send_item(bftk_pkg::CMD_FINISH, '0);
   endtask

   // receiver stalls while the sender keeps offering items
   task automatic test_backpressure();
      configure(1'b1, 16, 1, '0);
      load_query();
      repeat (16) send_db(16'($urandom), 1'b0);
      long_stall_cycles = 300;
      send_item(bftk_pkg::CMD_FINISH, '0, 1'b0);
      repeat (6) send_db(16'($urandom), 1'b0);
      send_item(bftk_pkg::CMD_FINISH, '0, 1'b0);
   endtask

   // well-formed query, stream and finish sequences with some noise
   task automatic test_random(int target);
      int start;
      int nvec;
      start = items_sent;
      while (items_sent - start < target) begin
         configure(1'($urandom_range(0, 1)), $urandom_range(0, 31),
                   ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 8),
                   IdW'($urandom));
         if ($urandom_range(0, 3) != 0) load_query();
         nvec = $urandom_range(0, 10);
         repeat (nvec * used_length()) begin
            case ($urandom_range(0, 29))
               0: send_item(bftk_pkg::CMD_UNUSED, 16'($urandom));
               1: send_item(bftk_pkg::CMD_QUERY, 16'($urandom));
               2: send_item(bftk_pkg::CMD_FINISH, '0);
               default: send_db(rand_elem());
            endcase
         end
         send_item(bftk_pkg::CMD_FINISH, '0);
      end
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_metrics_and_ties();
      test_special_cases();
      test_full_list();
      test_long_vector();
      test_backpressure();
      test_random(110);
      wait_idle();
      repeat (20) @(posedge clock);
      $display("Sent %0d items, checked %0d neighbours across both metrics,", items_sent,
               results_seen);
      $display("k and length extremes, id wrap, back-pressure and random sequences.");
      if (failures == 0 && pending_neighbours.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

### brute_force_topk_nearest_top.f
hw/rtl/bftk_pkg.sv
hw/rtl/bftk_ram.sv
hw/rtl/bftk_ctrl.sv
hw/rtl/bftk_dpath.sv
hw/rtl/brute_force_topk_nearest_top.sv
bench/tb_brute_force_topk_nearest_top.sv
